// File: src/srht_pkg.sv
// Shared types and constants for the segment/rectangle hit test.
// No dependencies.
`default_nettype none
package srht_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_COORDS     = 8;
    localparam int OUT_DATA_W     = 8;

    // Stage load enables handed from the top level to each edge unit.
    typedef struct packed {
        logic en1;
        logic en2;
    } t_stage_en;

endpackage
`default_nettype wire

// File: src/srht_edge.sv
// One rectangle edge against the segment: bounding-box overlap, differences,
// cross products, then straddle decision. Depends on srht_pkg.
`default_nettype none
module srht_edge
    import srht_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire  t_stage_en              i_en,
    input  wire  signed [COORD_BITS-1:0] i_ax,
    input  wire  signed [COORD_BITS-1:0] i_ay,
    input  wire  signed [COORD_BITS-1:0] i_bx,
    input  wire  signed [COORD_BITS-1:0] i_by,
    input  wire  signed [COORD_BITS-1:0] i_cx,
    input  wire  signed [COORD_BITS-1:0] i_cy,
    input  wire  signed [COORD_BITS-1:0] i_dx,
    input  wire  signed [COORD_BITS-1:0] i_dy,
    output logic                         o_meet
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    function automatic logic signed [DW-1:0] f_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [DW-1:0] ea;
        logic signed [DW-1:0] eb;
        ea = DW'(a);
        eb = DW'(b);
        return ea - eb;
    endfunction

    // stage 1: closed bounding-box overlap and coordinate differences
    logic signed [COORD_BITS-1:0] n_abx_lo, n_abx_hi, n_aby_lo, n_aby_hi;
    logic signed [COORD_BITS-1:0] n_cdx_lo, n_cdx_hi, n_cdy_lo, n_cdy_hi;
    logic                         n_box;

    always_comb begin
        n_abx_lo = (i_ax < i_bx) ? i_ax : i_bx;
        n_abx_hi = (i_ax > i_bx) ? i_ax : i_bx;
        n_aby_lo = (i_ay < i_by) ? i_ay : i_by;
        n_aby_hi = (i_ay > i_by) ? i_ay : i_by;
        n_cdx_lo = (i_cx < i_dx) ? i_cx : i_dx;
        n_cdx_hi = (i_cx > i_dx) ? i_cx : i_dx;
        n_cdy_lo = (i_cy < i_dy) ? i_cy : i_dy;
        n_cdy_hi = (i_cy > i_dy) ? i_cy : i_dy;
        n_box = !(n_abx_hi < n_cdx_lo || n_abx_lo > n_cdx_hi ||
                  n_aby_hi < n_cdy_lo || n_aby_lo > n_cdy_hi);
    end

    logic signed [DW-1:0] r_dcx, r_dcy, r_bcx, r_bcy, r_acx, r_acy;
    logic signed [DW-1:0] r_abx, r_aby, r_dbx, r_dby, r_cbx, r_cby;
    logic                 r_box1;

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_dcx  <= f_diff(i_dx, i_cx);
            r_dcy  <= f_diff(i_dy, i_cy);
            r_bcx  <= f_diff(i_bx, i_cx);
            r_bcy  <= f_diff(i_by, i_cy);
            r_acx  <= f_diff(i_ax, i_cx);
            r_acy  <= f_diff(i_ay, i_cy);
            r_abx  <= f_diff(i_ax, i_bx);
            r_aby  <= f_diff(i_ay, i_by);
            r_dbx  <= f_diff(i_dx, i_bx);
            r_dby  <= f_diff(i_dy, i_by);
            r_cbx  <= f_diff(i_cx, i_bx);
            r_cby  <= f_diff(i_cy, i_by);
            r_box1 <= n_box;
        end
    end

    // stage 2: the eight cross-product terms
    logic signed [PW-1:0] r_p1, r_q1, r_p2, r_q2, r_p3, r_q3, r_p4, r_q4;
    logic                 r_box2;

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_p1   <= PW'(r_dcx * r_bcy);
            r_q1   <= PW'(r_dcy * r_bcx);
            r_p2   <= PW'(r_dcx * r_acy);
            r_q2   <= PW'(r_dcy * r_acx);
            r_p3   <= PW'(r_abx * r_dby);
            r_q3   <= PW'(r_aby * r_dbx);
            r_p4   <= PW'(r_abx * r_cby);
            r_q4   <= PW'(r_aby * r_cbx);
            r_box2 <= r_box1;
        end
    end

    // stage 3 logic: nonzero and same sign on both sides rejects
    logic rej_cd, rej_ab;

    always_comb begin
        rej_cd = ((r_p1 > r_q1) && (r_p2 > r_q2)) || ((r_p1 < r_q1) && (r_p2 < r_q2));
        rej_ab = ((r_p3 > r_q3) && (r_p4 > r_q4)) || ((r_p3 < r_q3) && (r_p4 < r_q4));
        o_meet = r_box2 && !rej_cd && !rej_ab;
    end

endmodule
`default_nettype wire

// File: src/segment_rectangle_hit_test.sv
// The pipeline has one stage each for differences, products and the sign
// decision, from input transaction to result. Throughput: one transaction
// per cycle; each stage holds its item while the next is full, bubbles close.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
// Top level: an edge unit per rectangle side plus the inside test; depends on srht_pkg, srht_edge.
`default_nettype none
module segment_rectangle_hit_test
    import srht_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // seg_ax, seg_ay, seg_bx, seg_by, rect_ax, rect_ay, rect_bx, rect_by
    input  wire  [NUM_COORDS*COORD_BITS-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // hit, then zero fill
    output logic [OUT_DATA_W-1:0]           o_m_axis_tdata
);

    localparam int N = COORD_BITS;

    logic signed [N-1:0] ax, ay, bx, by, px, py, qx, qy;

    assign ax = $signed(i_s_axis_tdata[0*N +: N]);
    assign ay = $signed(i_s_axis_tdata[1*N +: N]);
    assign bx = $signed(i_s_axis_tdata[2*N +: N]);
    assign by = $signed(i_s_axis_tdata[3*N +: N]);
    assign px = $signed(i_s_axis_tdata[4*N +: N]);
    assign py = $signed(i_s_axis_tdata[5*N +: N]);
    assign qx = $signed(i_s_axis_tdata[6*N +: N]);
    assign qy = $signed(i_s_axis_tdata[7*N +: N]);

    // stage control
    logic      r_v1, r_v2, r_v3;
    logic      en3;
    t_stage_en en;

    always_comb begin
        en3     = !r_v3 || i_m_axis_tready;
        en.en2  = !r_v2 || en3;
        en.en1  = !r_v1 || en.en2;
    end

    assign o_s_axis_tready = en.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en.en1) r_v1 <= i_s_axis_tvalid;
            if (en.en2) r_v2 <= r_v1;
            if (en3)    r_v3 <= r_v2;
        end
    end

    // both endpoints inside or on the rectangle
    logic signed [N-1:0] xlo, xhi, ylo, yhi;
    logic                n_inside;

    always_comb begin
        xlo = (px < qx) ? px : qx;
        xhi = (px > qx) ? px : qx;
        ylo = (py < qy) ? py : qy;
        yhi = (py > qy) ? py : qy;
        n_inside = ax >= xlo && ax <= xhi && ay >= ylo && ay <= yhi &&
                   bx >= xlo && bx <= xhi && by >= ylo && by <= yhi;
    end

    logic r_in1, r_in2;

    always_ff @(posedge i_clk) begin
        if (en.en1) r_in1 <= n_inside;
        if (en.en2) r_in2 <= r_in1;
    end

    // edges P-(Px,Qy), (Px,Qy)-Q, Q-(Qx,Py), P-(Qx,Py)
    logic [3:0] meet;

    srht_edge #(.COORD_BITS(N)) u_edge0 (
        .i_clk(i_clk), .i_en(en),
        .i_ax(ax), .i_ay(ay), .i_bx(bx), .i_by(by),
        .i_cx(px), .i_cy(py), .i_dx(px), .i_dy(qy),
        .o_meet(meet[0])
    );

    srht_edge #(.COORD_BITS(N)) u_edge1 (
        .i_clk(i_clk), .i_en(en),
        .i_ax(ax), .i_ay(ay), .i_bx(bx), .i_by(by),
        .i_cx(px), .i_cy(qy), .i_dx(qx), .i_dy(qy),
        .o_meet(meet[1])
    );

    srht_edge #(.COORD_BITS(N)) u_edge2 (
        .i_clk(i_clk), .i_en(en),
        .i_ax(ax), .i_ay(ay), .i_bx(bx), .i_by(by),
        .i_cx(qx), .i_cy(qy), .i_dx(qx), .i_dy(py),
        .o_meet(meet[2])
    );

    srht_edge #(.COORD_BITS(N)) u_edge3 (
        .i_clk(i_clk), .i_en(en),
        .i_ax(ax), .i_ay(ay), .i_bx(bx), .i_by(by),
        .i_cx(px), .i_cy(py), .i_dx(qx), .i_dy(py),
        .o_meet(meet[3])
    );

    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (en3) r_hit <= r_in2 || (|meet);
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, r_hit};

endmodule
`default_nettype wire
